@@ hdl/pgbsp_pkg.sv @@
package pgbsp_pkg;

	localparam int ADDR_W   = 64;
	localparam int PAGE_W   = 10;
	localparam int COUNT_W  = 16;
	localparam int SIZE_W   = 31;
	localparam int INDEX_W  = 2;
	localparam int ACTION_W = 2;

	localparam int S_DATA_W = 152;
	localparam int M_DATA_W = 184;

	localparam logic [INDEX_W-1:0] REG_TIMEOUT_FAULTS  = 2'd0;
	localparam logic [INDEX_W-1:0] REG_BLOCK_SIZE      = 2'd1;
	localparam logic [INDEX_W-1:0] REG_PREFETCH_LENGTH = 2'd2;

	localparam logic [COUNT_W-1:0] TIMEOUT_RESET  = 16'd500;
	localparam logic [SIZE_W-1:0]  BLOCK_RESET    = 31'd2097152;
	localparam logic [SIZE_W-1:0]  LENGTH_RESET   = 31'd2097152;
	localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

	typedef enum logic [ACTION_W-1:0] {
		KIND_DECODE  = 2'd0,
		KIND_FAULT   = 2'd1,
		KIND_REQUEST = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic               present;
		logic [ADDR_W-1:0]  end_addr;
		logic [ADDR_W-1:0]  space_id;
		logic [PAGE_W-1:0]  region_first;
		logic [PAGE_W-1:0]  region_outer;
	} item_t;

	typedef struct packed {
		logic               in_decode;
		logic [SIZE_W-1:0]  target_length;
		logic [ADDR_W-1:0]  target_space;
		logic [ADDR_W-1:0]  target_addr;
		logic [PAGE_W-1:0]  out_region_outer;
		logic [PAGE_W-1:0]  out_region_first;
		logic               issue;
	} result_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

@@ hdl/pgbsp_front.sv @@
module pgbsp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [pgbsp_pkg::ACTION_W-1:0]   action,
	input  logic [pgbsp_pkg::S_DATA_W-1:0]   data,
	output pgbsp_pkg::queue_head_t           head,
	input  logic                             pop
);
	import pgbsp_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      item_in;
	logic       push;

	always_comb begin
		item_in.kind         = kind_t'(action);
		item_in.present      = data[0];
		item_in.end_addr     = data[64:1];
		item_in.space_id     = data[128:65];
		item_in.region_first = data[138:129];
		item_in.region_outer = data[148:139];
	end

	assign in_ready   = (cnt_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ hdl/pgbsp_back.sv @@
module pgbsp_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pgbsp_pkg::queue_head_t           head,
	output logic                             pop,
	input  logic                             wr_en,
	input  logic [pgbsp_pkg::INDEX_W-1:0]    wr_index,
	input  logic [pgbsp_pkg::SIZE_W-1:0]     wr_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pgbsp_pkg::result_t               result
);
	import pgbsp_pkg::*;

	logic [COUNT_W-1:0] timeout_q;
	logic [SIZE_W-1:0]  block_size_q;
	logic [SIZE_W-1:0]  length_q;

	logic               phase_q;
	logic [COUNT_W-1:0] count_q;
	logic [ADDR_W-1:0]  cend_q;
	logic [ADDR_W-1:0]  cspace_q;
	logic [ADDR_W-1:0]  older_q;
	logic [ADDR_W-1:0]  newest_q;
	logic [ADDR_W-1:0]  last_q;

	logic               out_valid_q;
	result_t            result_q;

	logic               phase_d;
	logic [COUNT_W-1:0] count_d;
	logic [COUNT_W-1:0] count_inc;
	logic [ADDR_W-1:0]  cend_d;
	logic [ADDR_W-1:0]  cspace_d;
	logic [ADDR_W-1:0]  older_d;
	logic [ADDR_W-1:0]  newest_d;
	logic [ADDR_W-1:0]  last_d;
	logic [ADDR_W-1:0]  step1;
	logic [ADDR_W-1:0]  step2;
	logic [ADDR_W-1:0]  target;
	logic               same_dir;
	result_t            res_d;

	assign pop       = head.valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	assign step1 = newest_q - older_q;
	assign step2 = cend_q - newest_q;
	assign same_dir = (step1 != '0) && (step2 != '0)
		&& (step1[ADDR_W-1] == step2[ADDR_W-1]);
	assign target = step2[ADDR_W-1] ? (cend_q - {{(ADDR_W-SIZE_W){1'b0}}, block_size_q})
		: (cend_q + 64'd1);
	assign count_inc = (count_q != COUNT_MAX) ? count_q + 16'd1 : count_q;

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		cend_d   = cend_q;
		cspace_d = cspace_q;
		older_d  = older_q;
		newest_d = newest_q;
		last_d   = last_q;
		res_d    = '0;
		unique case (head.item.kind)
			KIND_DECODE: begin
				phase_d = 1'b1;
				count_d = '0;
			end
			KIND_FAULT: begin
				if (!head.item.present) begin
					cend_d   = '0;
					cspace_d = '0;
				end else begin
					cend_d   = head.item.end_addr;
					cspace_d = head.item.space_id;
					if (phase_q) begin
						count_d  = count_inc;
						cspace_d = '0;
						if (count_inc > timeout_q) begin
							phase_d  = 1'b0;
							count_d  = '0;
							cspace_d = head.item.space_id;
						end
					end
				end
			end
			KIND_REQUEST: begin
				res_d.out_region_first = head.item.region_first;
				res_d.out_region_outer = head.item.region_outer;
				if (!phase_q && cspace_q != '0 && cend_q != '0 && cend_q != newest_q) begin
					older_d  = newest_q;
					newest_d = cend_q;
					if (older_q != '0 && newest_q != '0 && same_dir
						&& target != '0 && target != last_q) begin
						last_d              = target;
						res_d.issue         = 1'b1;
						res_d.target_addr   = target;
						res_d.target_space  = cspace_q;
						res_d.target_length = length_q;
					end
				end
			end
			default: begin
			end
		endcase
		res_d.in_decode = phase_d;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= TIMEOUT_RESET;
			block_size_q <= BLOCK_RESET;
			length_q     <= LENGTH_RESET;
			phase_q      <= 1'b0;
			count_q      <= '0;
			cend_q       <= '0;
			cspace_q     <= '0;
			older_q      <= '0;
			newest_q     <= '0;
			last_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_TIMEOUT_FAULTS:  timeout_q    <= wr_data[COUNT_W-1:0];
					REG_BLOCK_SIZE:      block_size_q <= wr_data;
					REG_PREFETCH_LENGTH: length_q     <= wr_data;
					default: begin
					end
				endcase
			end
			if (pop) begin
				phase_q  <= phase_d;
				count_q  <= count_d;
				cend_q   <= cend_d;
				cspace_q <= cspace_d;
				older_q  <= older_d;
				newest_q <= newest_d;
				last_q   <= last_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/phase_gated_block_stride_prefetcher.sv @@
// Phase-gated block stride prefetcher.
// Input words arrive on the s_ group: s_tuser carries the action (decode
// marker, fault, prefetch request), s_tdata the block and region fields.
// Every word yields exactly one result word on the m_ group: the chosen page
// region, the phase after the event and, when issued, one cross-block
// prefetch target with its space and length (m_tuser flags the issue).
// Accepted words enter a two-entry queue; the back end takes one word per
// cycle from it while the output register is empty or being read, updates
// the phase and stride history and loads the output register. m_tvalid rises
// once a word has passed its queue entry and the output register.
// When the receiver stalls the output register holds its word, the queue
// fills and s_tready drops once both entries are taken.
// Registers are written on the plain port (wr_en, wr_index, wr_data); the
// user must do so only while idle, unchecked by the block. Reset empties
// queue and output, sets prefill, clears history; defaults 500, 2 MiB, 2 MiB.
module phase_gated_block_stride_prefetcher (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [0] block_present, [64:1] end address, [128:65] space_id,
	// [138:129] region_first, [148:139] region_outer, [151:149] zero
	input  logic [pgbsp_pkg::S_DATA_W-1:0]   s_tdata,
	// [1:0] action
	input  logic [pgbsp_pkg::ACTION_W-1:0]   s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [9:0] out_region_first, [19:10] out_region_outer, [83:20] target_addr,
	// [147:84] target_space, [178:148] target_length, [179] in_decode,
	// [183:180] zero
	output logic [pgbsp_pkg::M_DATA_W-1:0]   m_tdata,
	// [0] issue
	output logic                             m_tuser,
	input  logic                             wr_en,
	input  logic [pgbsp_pkg::INDEX_W-1:0]    wr_index,
	input  logic [pgbsp_pkg::SIZE_W-1:0]     wr_data
);
	import pgbsp_pkg::*;

	queue_head_t head;
	logic        pop;
	result_t     result;

	pgbsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.action   (s_tuser),
		.data     (s_tdata),
		.head     (head),
		.pop      (pop)
	);

	pgbsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result    (result)
	);

	assign m_tuser = result.issue;
	assign m_tdata = {4'd0, result.in_decode, result.target_length, result.target_space,
		result.target_addr, result.out_region_outer, result.out_region_first};

endmodule
